>>> hdl/generational_handle_slot_table_defines.svh
// Assertion macros for the generational handle slot table.
`ifndef GENERATIONAL_HANDLE_SLOT_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_SLOT_TABLE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define GHST_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define GHST_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define GHST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ghst_pkg.sv
// Types and constants of the generational handle slot table.
`default_nettype none

package ghst_pkg;

    localparam int SLOTS       = 256;
    localparam int GEN_BITS    = 16;
    localparam int REF_BITS    = 32;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int CNT_BITS    = SLOT_BITS + 1;
    localparam int REQ_BITS    = 2;
    localparam int STATUS_BITS = 3;

    localparam logic [CNT_BITS-1:0] SLOT_LIMIT = CNT_BITS'(SLOTS);

    typedef enum logic [REQ_BITS-1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_LOOKUP = 2'd2
    } t_req;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 3'd0,
        ST_NULL  = 3'd1,
        ST_FULL  = 3'd2,
        ST_RANGE = 3'd3,
        ST_STALE = 3'd4
    } t_status;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [GEN_BITS-1:0]  gen;
    } t_free_entry;

    typedef struct packed {
        logic                 obj_en;
        logic                 gen_en;
        logic [SLOT_BITS-1:0] addr;
        logic [REF_BITS-1:0]  obj_data;
        logic [GEN_BITS-1:0]  gen_data;
    } t_slot_wr;

    function automatic logic [SLOT_BITS-1:0] wrap_next(input logic [SLOT_BITS-1:0] p);
        return (p == SLOT_BITS'(SLOTS - 1)) ? '0 : p + SLOT_BITS'(1);
    endfunction

endpackage

`default_nettype wire

>>> hdl/generational_handle_slot_table.sv
// Generational handle slot table: allocate, free and lookup of slot handles.
//
//   channel   direction   handshake            fields
//   request   in          i_valid / o_stall    req_type object_ref slot_index
//                                              handle_generation
//   result    out         o_valid / i_stall    status result_slot
//                                              result_generation result_ref
//
// One request beat per cycle while o_stall is low. The slot memories are read into
// registers at accept; the update of memories, free queue and counters then
// registers the result beat.
// Reset is synchronous; slot memories need no clearing, the never-used count
// bounds every read and the free queue stores a slot's generation with it.
// A stalled result holds the update stage, and then the request side stalls.
`default_nettype none
`include "generational_handle_slot_table_defines.svh"

module generational_handle_slot_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ghst_pkg::REQ_BITS-1:0]       i_req_type,
    input  logic [ghst_pkg::REF_BITS-1:0]       i_object_ref,
    input  logic [ghst_pkg::SLOT_BITS-1:0]      i_slot_index,
    input  logic [ghst_pkg::GEN_BITS-1:0]       i_handle_generation,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ghst_pkg::STATUS_BITS-1:0]    o_status,
    output logic [ghst_pkg::SLOT_BITS-1:0]      o_result_slot,
    output logic [ghst_pkg::GEN_BITS-1:0]       o_result_generation,
    output logic [ghst_pkg::REF_BITS-1:0]       o_result_ref
);
    import ghst_pkg::*;

    logic [REF_BITS-1:0]  obj_mem [SLOTS];
    logic [GEN_BITS-1:0]  gen_mem [SLOTS];
    t_free_entry          fifo_mem [SLOTS];

    logic                 r_s1_valid;
    logic [REQ_BITS-1:0]  r_s1_req;
    logic [REF_BITS-1:0]  r_s1_obj;
    logic [SLOT_BITS-1:0] r_s1_idx;
    logic [GEN_BITS-1:0]  r_s1_hgen;
    logic [REF_BITS-1:0]  r_rd_obj;
    logic [GEN_BITS-1:0]  r_rd_gen;

    logic [CNT_BITS-1:0]  r_next_unused;
    logic [CNT_BITS-1:0]  r_free_count;
    logic [SLOT_BITS-1:0] r_head;
    logic [SLOT_BITS-1:0] r_tail;
    t_free_entry          r_head_entry;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [SLOT_BITS-1:0] r_out_slot;
    logic [GEN_BITS-1:0]  r_out_gen;
    logic [REF_BITS-1:0]  r_out_obj;

    logic                 adv;
    logic                 accept;
    logic                 in_range;
    logic                 pop;
    logic                 push;
    logic                 claim;
    t_slot_wr             w;
    t_free_entry          push_entry;
    logic [SLOT_BITS-1:0] n_head;
    t_status              res_status;
    logic [SLOT_BITS-1:0] res_slot;
    logic [GEN_BITS-1:0]  res_gen;
    logic [REF_BITS-1:0]  res_obj;

    assign adv      = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_s1_valid && !adv;
    assign accept   = i_valid && !o_stall;
    assign in_range = {1'b0, r_s1_idx} < r_next_unused;

    assign push_entry.slot = r_s1_idx;
    assign push_entry.gen  = r_rd_gen;

    assign n_head = (adv && pop) ? wrap_next(r_head) : r_head;

    // update stage: decide the operation against current table state
    always_comb begin
        w          = '0;
        pop        = 1'b0;
        push       = 1'b0;
        claim      = 1'b0;
        res_status = ST_OK;
        res_slot   = '0;
        res_gen    = '0;
        res_obj    = '0;
        case (r_s1_req)
            REQ_ALLOC: begin
                if (r_s1_obj == '0) begin
                    res_status = ST_NULL;
                end else if (r_free_count != '0) begin
                    pop      = 1'b1;
                    res_slot = r_head_entry.slot;
                    res_gen  = r_head_entry.gen + GEN_BITS'(1);
                end else if (r_next_unused < SLOT_LIMIT) begin
                    claim    = 1'b1;
                    res_slot = r_next_unused[SLOT_BITS-1:0];
                    res_gen  = GEN_BITS'(1);
                end else begin
                    res_status = ST_FULL;
                end
                w.obj_en   = pop || claim;
                w.gen_en   = pop || claim;
                w.addr     = res_slot;
                w.obj_data = r_s1_obj;
                w.gen_data = res_gen;
            end
            REQ_FREE: begin
                if (!in_range) begin
                    res_status = ST_RANGE;
                end else if (r_rd_obj == '0) begin
                    res_status = ST_STALE;
                end else begin
                    w.obj_en = 1'b1;
                    w.addr   = r_s1_idx;
                    push     = r_free_count < SLOT_LIMIT;
                end
            end
            REQ_LOOKUP: begin
                if (!in_range) begin
                    res_status = ST_RANGE;
                end else if (r_rd_gen != r_s1_hgen || r_rd_obj == '0) begin
                    res_status = ST_STALE;
                end else begin
                    res_obj = r_rd_obj;
                end
            end
            default: begin
                res_status = ST_RANGE;
            end
        endcase
    end

    // slot memories: write from update stage, read at accept with bypass
    always_ff @(posedge i_clk) begin
        if (adv && w.obj_en) begin
            obj_mem[w.addr] <= w.obj_data;
        end
        if (accept) begin
            if (adv && w.obj_en && w.addr == i_slot_index) begin
                r_rd_obj <= w.obj_data;
            end else begin
                r_rd_obj <= obj_mem[i_slot_index];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && w.gen_en) begin
            gen_mem[w.addr] <= w.gen_data;
        end
        if (accept) begin
            if (adv && w.gen_en && w.addr == i_slot_index) begin
                r_rd_gen <= w.gen_data;
            end else begin
                r_rd_gen <= gen_mem[i_slot_index];
            end
        end
    end

    // free queue: keep the head entry prefetched
    always_ff @(posedge i_clk) begin
        if (adv && push) begin
            fifo_mem[r_tail] <= push_entry;
        end
        if (adv && push && r_tail == n_head) begin
            r_head_entry <= push_entry;
        end else begin
            r_head_entry <= fifo_mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_next_unused <= '0;
            r_free_count  <= '0;
            r_head        <= '0;
            r_tail        <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            r_head <= n_head;
            if (adv && push) begin
                r_tail       <= wrap_next(r_tail);
                r_free_count <= r_free_count + CNT_BITS'(1);
            end else if (adv && pop) begin
                r_free_count <= r_free_count - CNT_BITS'(1);
            end
            if (adv && claim) begin
                r_next_unused <= r_next_unused + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req  <= i_req_type;
            r_s1_obj  <= i_object_ref;
            r_s1_idx  <= i_slot_index;
            r_s1_hgen <= i_handle_generation;
        end
        if (adv) begin
            r_out_status <= res_status;
            r_out_slot   <= res_slot;
            r_out_gen    <= res_gen;
            r_out_obj    <= res_obj;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_out_status;
    assign o_result_slot       = r_out_slot;
    assign o_result_generation = r_out_gen;
    assign o_result_ref        = r_out_obj;

    `GHST_ASSERT_ALWAYS(a_free_le_used, r_free_count <= r_next_unused, "free count above used slots")
    `GHST_ASSERT_ALWAYS(a_unused_bound, r_next_unused <= SLOT_LIMIT, "never-used index past table")
    `GHST_ASSERT_IMPLY(a_pop_nonempty, adv && pop, r_free_count != '0, "pop from empty free queue")
    `GHST_ASSERT_IMPLY(a_one_side, adv && push, !pop && !claim, "push together with allocation")
    `GHST_ASSERT_NEXT(a_adv_result, adv, r_out_valid, "advanced beat missing at output")

endmodule

`default_nettype wire
